@@ rtl/qedp_pkg.sv @@
// Shared types and codes for the quad edge dof pair generator.
package qedp_pkg;

    localparam int unsigned MAX_ORDER_DEF = 15;
    localparam int unsigned COUNT_W       = 4;
    localparam int unsigned IDX_W         = 32;
    localparam int unsigned OFF_W         = 12;
    localparam int unsigned STRIDE_W      = 6;

    localparam logic [1:0] ACT_EDGE   = 2'd0;
    localparam logic [1:0] ACT_INNER  = 2'd1;
    localparam logic [1:0] ACT_CORNER = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIDE = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [3:0]       order_a;
        logic [1:0]       side_a;
        logic [IDX_W-1:0] base_a;
        logic [3:0]       order_b;
        logic [1:0]       side_b;
        logic [IDX_W-1:0] base_b;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic             last;
        logic [1:0]       status;
    } rsp_t;

    // Local offsets and strides of both sides, from the layout logic.
    typedef struct packed {
        logic signed [OFF_W-1:0]    off_a;
        logic signed [OFF_W-1:0]    off_b;
        logic signed [STRIDE_W-1:0] stride_a;
        logic signed [STRIDE_W-1:0] stride_b;
    } lay_t;

    // Commands from the sequencer to the index unit.
    typedef struct packed {
        logic load;
        logic step;
    } ctl_t;

    // Result marking from the sequencer.
    typedef struct packed {
        logic valid;
        logic last;
        logic err;
    } mark_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMIT,
        ST_ERR
    } state_t;

endpackage

@@ rtl/qedp_layout.sv @@
// Side layout: local start offsets and strides of both elements.
module qedp_layout (
    input  qedp_pkg::req_t req,
    output qedp_pkg::lay_t lay
);

    typedef struct packed {
        logic signed [qedp_pkg::OFF_W-1:0]    start;
        logic signed [qedp_pkg::STRIDE_W-1:0] step;
    } side_t;

    function automatic side_t side_layout(input logic nodes, input logic [3:0] p,
                                          input logic [1:0] side);
        logic signed [qedp_pkg::OFF_W-1:0]    p12;
        logic signed [qedp_pkg::OFF_W-1:0]    n12;
        logic signed [qedp_pkg::OFF_W-1:0]    pn12;
        logic signed [qedp_pkg::STRIDE_W-1:0] n6;
        side_t r;
        p12  = $signed({{(qedp_pkg::OFF_W-4){1'b0}}, p});
        n12  = p12 + 12'sd1;
        pn12 = p12 * n12;
        n6   = $signed(n12[qedp_pkg::STRIDE_W-1:0]);
        case (side)
            2'd0:
            begin
                r.start = '0;
                r.step  = 6'sd1;
            end
            2'd1:
            begin
                r.start = nodes ? p12 : pn12 + p12;
                r.step  = n6;
            end
            2'd2:
            begin
                r.start = nodes ? (n12 * n12) - 12'sd1 : pn12 - 12'sd1;
                r.step  = -6'sd1;
            end
            default:
            begin
                r.start = nodes ? pn12 : (pn12 <<< 1) - n12;
                r.step  = -n6;
            end
        endcase
        return r;
    endfunction

    logic                              nodes;
    side_t                             sa;
    side_t                             sb;
    logic signed [qedp_pkg::OFF_W-1:0] mult;
    logic signed [qedp_pkg::OFF_W-1:0] db12;

    always_comb
    begin
        nodes = (req.action != qedp_pkg::ACT_EDGE);
        sa    = side_layout(nodes, req.order_a, req.side_a);
        sb    = side_layout(nodes, req.order_b, req.side_b);
        // Second side starts at its far end: p-1 steps in, p for the corner.
        mult  = $signed({{(qedp_pkg::OFF_W-4){1'b0}}, req.order_a});
        if (req.action != qedp_pkg::ACT_CORNER)
        begin
            mult = mult - 12'sd1;
        end
        db12         = {{(qedp_pkg::OFF_W-qedp_pkg::STRIDE_W){sb.step[qedp_pkg::STRIDE_W-1]}},
                        sb.step};
        lay.off_a    = (req.action == qedp_pkg::ACT_INNER) ?
                       sa.start + {{(qedp_pkg::OFF_W-qedp_pkg::STRIDE_W){sa.step[qedp_pkg::STRIDE_W-1]}},
                                   sa.step} : sa.start;
        lay.off_b    = sb.start + mult * db12;
        lay.stride_a = sa.step;
        lay.stride_b = sb.step;
    end

endmodule

@@ rtl/qedp_index_unit.sv @@
// Shared index unit: loads the walk starts and advances both indices.
module qedp_index_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qedp_pkg::ctl_t               ctl,
    input  qedp_pkg::lay_t               lay,
    input  logic [qedp_pkg::IDX_W-1:0]   base_a,
    input  logic [qedp_pkg::IDX_W-1:0]   base_b,
    output logic [qedp_pkg::IDX_W-1:0]   index_a,
    output logic [qedp_pkg::IDX_W-1:0]   index_b
);

    localparam int unsigned W = qedp_pkg::IDX_W;

    logic [W-1:0] acc_a_reg, acc_a_next;
    logic [W-1:0] acc_b_reg, acc_b_next;
    logic [W-1:0] opx_a, opy_a, opx_b, opy_b;
    logic [W-1:0] stride_a32, stride_b32;

    always_comb
    begin
        stride_a32 = {{(W-qedp_pkg::STRIDE_W){lay.stride_a[qedp_pkg::STRIDE_W-1]}},
                      lay.stride_a};
        stride_b32 = {{(W-qedp_pkg::STRIDE_W){lay.stride_b[qedp_pkg::STRIDE_W-1]}},
                      lay.stride_b};
        // Load: base plus local offset. Step: walk a forward, b backward.
        opx_a = ctl.load ? base_a : acc_a_reg;
        opx_b = ctl.load ? base_b : acc_b_reg;
        opy_a = ctl.load ? {{(W-qedp_pkg::OFF_W){lay.off_a[qedp_pkg::OFF_W-1]}}, lay.off_a}
                         : stride_a32;
        opy_b = ctl.load ? {{(W-qedp_pkg::OFF_W){lay.off_b[qedp_pkg::OFF_W-1]}}, lay.off_b}
                         : (~stride_b32 + {{(W-1){1'b0}}, 1'b1});
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        if (ctl.load || ctl.step)
        begin
            acc_a_next = opx_a + opy_a;
            acc_b_next = opx_b + opy_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_a_reg <= '0;
            acc_b_reg <= '0;
        end
        else
        begin
            acc_a_reg <= acc_a_next;
            acc_b_reg <= acc_b_next;
        end
    end

    assign index_a = acc_a_reg;
    assign index_b = acc_b_reg;

endmodule

@@ rtl/qedp_ctrl.sv @@
// Sequencer: request decode, pair count and result marking.
module qedp_ctrl #(
    parameter int unsigned MAX_ORDER = qedp_pkg::MAX_ORDER_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        action,
    input  logic [3:0]        order_a,
    input  logic [3:0]        order_b,
    output logic              busy,
    output qedp_pkg::ctl_t    ctl,
    output qedp_pkg::mark_t   mark
);

    localparam int unsigned CAP = (MAX_ORDER < 15) ? MAX_ORDER : 15;
    localparam logic [qedp_pkg::COUNT_W-1:0] CAP_C = CAP[qedp_pkg::COUNT_W-1:0];

    qedp_pkg::state_t state_reg, state_next;
    logic [qedp_pkg::COUNT_W-1:0] steps_left_reg, steps_left_next;
    logic [qedp_pkg::COUNT_W-1:0] count_raw, count;

    always_comb
    begin
        case (action)
            qedp_pkg::ACT_EDGE:   count_raw = order_a;
            qedp_pkg::ACT_INNER:  count_raw = (order_a > 4'd1) ? order_a - 4'd1 : 4'd0;
            qedp_pkg::ACT_CORNER: count_raw = 4'd1;
            default:              count_raw = 4'd0;
        endcase
        count = (count_raw > CAP_C) ? CAP_C : count_raw;
    end

    // Next state
    always_comb
    begin
        state_next      = state_reg;
        steps_left_next = steps_left_reg;
        case (state_reg)
            qedp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = qedp_pkg::ST_LOAD;
                end
            end
            qedp_pkg::ST_LOAD:
            begin
                if (action == qedp_pkg::ACT_NONE)
                begin
                    state_next = qedp_pkg::ST_IDLE;
                end
                else if (order_a != order_b)
                begin
                    state_next = qedp_pkg::ST_ERR;
                end
                else if (count == '0)
                begin
                    state_next = qedp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next      = qedp_pkg::ST_EMIT;
                    steps_left_next = count;
                end
            end
            qedp_pkg::ST_EMIT:
            begin
                steps_left_next = steps_left_reg - 1'b1;
                if (steps_left_reg == 4'd1)
                begin
                    state_next = qedp_pkg::ST_IDLE;
                end
            end
            qedp_pkg::ST_ERR:
            begin
                state_next = qedp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = qedp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy       = 1'b1;
        ctl.load   = 1'b0;
        ctl.step   = 1'b0;
        mark.valid = 1'b0;
        mark.last  = 1'b0;
        mark.err   = 1'b0;
        case (state_reg)
            qedp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            qedp_pkg::ST_LOAD:
            begin
                ctl.load = 1'b1;
            end
            qedp_pkg::ST_EMIT:
            begin
                ctl.step   = 1'b1;
                mark.valid = 1'b1;
                mark.last  = (steps_left_reg == 4'd1);
            end
            qedp_pkg::ST_ERR:
            begin
                mark.valid = 1'b1;
                mark.last  = 1'b1;
                mark.err   = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qedp_pkg::ST_IDLE;
            steps_left_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
        end
    end

endmodule

@@ rtl/quad_edge_dof_pair_generator.sv @@
// Top level of the quad edge dof pair generator.
//
//  channel   ports                    transfer
//  --------  -----------------------  -----------------------------------------
//  request   start, busy, request     edge with start high and busy low
//  result    valid, result            edge ending each cycle with valid high
//
// Sequence: the transfer edge latches the request; the LOAD state loads both
// walk starts into the index unit; then one result per cycle, up to
// min(MAX_ORDER, 15) results, before the next request is taken (the result
// count is order, order-1, or 1 for the corner node; one result on order
// mismatch; none for the unused action or an empty walk).
// The rate is set by the two-lane index adder, which adds one stride per cycle.
// Reset clears the sequencer and index registers; the block is idle after it.
// The receiver cannot stall: each result sits on the ports for one cycle only.
module quad_edge_dof_pair_generator #(
    parameter int unsigned MAX_ORDER = qedp_pkg::MAX_ORDER_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  qedp_pkg::req_t request,
    output logic           valid,
    output qedp_pkg::rsp_t result
);

    qedp_pkg::req_t  req_reg;
    qedp_pkg::lay_t  lay;
    qedp_pkg::ctl_t  ctl;
    qedp_pkg::mark_t mark;
    logic            accept;
    logic [qedp_pkg::IDX_W-1:0] index_a;
    logic [qedp_pkg::IDX_W-1:0] index_b;

    assign accept = start && !busy;

    // Hold the request for the whole walk.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    qedp_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (req_reg.action),
        .order_a (req_reg.order_a),
        .order_b (req_reg.order_b),
        .busy    (busy),
        .ctl     (ctl),
        .mark    (mark)
    );

    qedp_layout u_layout (
        .req (req_reg),
        .lay (lay)
    );

    qedp_index_unit u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .lay     (lay),
        .base_a  (req_reg.base_a),
        .base_b  (req_reg.base_b),
        .index_a (index_a),
        .index_b (index_b)
    );

    // Drive the result from the index registers; zero indices on error.
    always_comb
    begin
        valid          = mark.valid;
        result.index_a = mark.err ? '0 : index_a;
        result.index_b = mark.err ? '0 : index_b;
        result.last    = mark.last;
        result.status  = mark.err ? qedp_pkg::STATUS_MISMATCH : qedp_pkg::STATUS_OK;
    end

endmodule

@@ bench/tb.sv @@
// Testbench for the quad edge dof pair generator: directed and random requests, predicted pairs.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned PAIR_CAP     = qedp_pkg::MAX_ORDER_DEF;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          RANDOM_ITEMS = 390;
    localparam int          REQ_W        = $bits(qedp_pkg::req_t);

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    qedp_pkg::req_t request;
    logic           valid;
    qedp_pkg::rsp_t result;

    // Pairs still owed by the block, oldest first.
    qedp_pkg::rsp_t pending_pairs[$];

    int    sent_count;
    int    pair_count;
    int    error_count;
    int    cycle_count;

    quad_edge_dof_pair_generator #(
        .MAX_ORDER (PAIR_CAP)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .valid   (valid),
        .result  (result)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d pairs still pending",
                     cycle_count, pending_pairs.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Local start and step of one side; the step wraps as a 32-bit value.
    function automatic void side_layout(input logic nodes, input logic [31:0] p,
                                        input logic [1:0] side,
                                        output logic [31:0] first,
                                        output logic [31:0] step);
        logic [31:0] n;
        n = p + 32'd1;
        case (side)
            2'd0:
            begin
                first = 32'd0;
                step  = 32'd1;
            end
            2'd1:
            begin
                first = nodes ? p : p * n + p;
                step  = n;
            end
            2'd2:
            begin
                first = nodes ? n * n - 32'd1 : p * n - 32'd1;
                step  = 32'hFFFF_FFFF;
            end
            default:
            begin
                first = nodes ? p * n : 32'd2 * p * n - n;
                step  = 32'd0 - n;
            end
        endcase
    endfunction

    // Work out every index pair one request owes and queue them in order.
    function automatic void predict_pairs(input qedp_pkg::req_t r);
        logic [31:0]    off_a, step_a, off_b, step_b;
        logic [31:0]    p, walk_a, walk_b, k;
        int unsigned    count;
        qedp_pkg::rsp_t pair;
        pair = '0;
        if (r.action == qedp_pkg::ACT_NONE)
            return;
        if (r.order_a != r.order_b)
        begin
            pair.last   = 1'b1;
            pair.status = qedp_pkg::STATUS_MISMATCH;
            pending_pairs.push_back(pair);
            return;
        end
        p = {28'd0, r.order_a};
        side_layout(r.action != qedp_pkg::ACT_EDGE, p, r.side_a, off_a, step_a);
        side_layout(r.action != qedp_pkg::ACT_EDGE, p, r.side_b, off_b, step_b);
        case (r.action)
            qedp_pkg::ACT_EDGE:
            begin
                count  = p;
                walk_a = off_a + r.base_a;
                walk_b = off_b + (p - 32'd1) * step_b + r.base_b;
            end
            qedp_pkg::ACT_INNER:
            begin
                count  = (p > 32'd1) ? p - 32'd1 : 0;
                walk_a = off_a + step_a + r.base_a;
                walk_b = off_b + (p - 32'd1) * step_b + r.base_b;
            end
            default:
            begin
                count  = 1;
                walk_a = off_a + r.base_a;
                walk_b = off_b + p * step_b + r.base_b;
            end
        endcase
        if (count > PAIR_CAP)
            count = PAIR_CAP;
        for (int unsigned i = 0; i < count; i++)
        begin
            k            = i;
            pair.index_a = walk_a + k * step_a;
            pair.index_b = walk_b - k * step_b;
            pair.last    = (i + 1 == count);
            pair.status  = qedp_pkg::STATUS_OK;
            pending_pairs.push_back(pair);
        end
    endfunction

    // Sample at the rising edge: check any result first, then predict for
    // a request transferred at this same edge.
    always @(posedge clk)
    begin
        qedp_pkg::rsp_t want;
        if (rst_n)
        begin
            if (valid)
            begin
                pair_count++;
                if (pending_pairs.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("[%0t] unexpected result a=%h b=%h last=%b status=%0d",
                                 $time, result.index_a, result.index_b,
                                 result.last, result.status);
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    if (result.index_a !== want.index_a || result.index_b !== want.index_b
                        || result.last !== want.last || result.status !== want.status)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("[%0t] exp a=%h b=%h l=%b s=%0d got a=%h b=%h l=%b s=%0d",
                                     $time, want.index_a, want.index_b, want.last,
                                     want.status, result.index_a, result.index_b,
                                     result.last, result.status);
                    end
                end
            end
            if (start && !busy)
                predict_pairs(request);
        end
    end

    function automatic qedp_pkg::req_t make_request(input logic [1:0] action,
                                                    input logic [3:0] pa,
                                                    input logic [1:0] sa,
                                                    input logic [31:0] ba,
                                                    input logic [3:0] pb,
                                                    input logic [1:0] sb,
                                                    input logic [31:0] bb);
        qedp_pkg::req_t r;
        r.action  = action;
        r.order_a = pa;
        r.side_a  = sa;
        r.base_a  = ba;
        r.order_b = pb;
        r.side_b  = sb;
        r.base_b  = bb;
        return r;
    endfunction

    // Present one request at the falling edge and hold it until the
    // transfer edge; leave start high so a back-to-back request follows.
    task automatic send_request(input qedp_pkg::req_t r);
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
    endtask

    // Drop start for a random number of cycles and scramble the idle bus.
    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start   <= 1'b0;
            request <= REQ_W'({$urandom, $urandom, $urandom});
        end
    endtask

    function automatic logic [31:0] random_base();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'hFFFF_FFFF - $urandom_range(0, 255);
        if (pick == 1)
            return $urandom_range(0, 255);
        return $urandom;
    endfunction

    // Mostly matching orders in a valid mode; the rest mismatches and the
    // unused action. Order zero shows up now and then.
    function automatic qedp_pkg::req_t random_request();
        qedp_pkg::req_t r;
        int unsigned    pick;
        logic [3:0]     order;
        pick  = $urandom_range(0, 99);
        order = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        r = make_request(2'($urandom_range(0, 2)), order, 2'($urandom_range(0, 3)),
                         random_base(), order, 2'($urandom_range(0, 3)), random_base());
        if (pick < 10)
        begin
            while (r.order_b == r.order_a)
                r.order_b = 4'($urandom_range(0, 15));
        end
        else if (pick < 15)
            r.action = qedp_pkg::ACT_NONE;
        return r;
    endfunction

    // Edge dofs at full order for side pairs (s, 3-s) and (2, 2), plus an order-1 walk, with wrapping bases.
    task automatic test_edge_walks();
        for (int s = 0; s < 4; s++)
            send_request(make_request(qedp_pkg::ACT_EDGE, 4'd15, 2'(s), 32'hFFFF_FFFF,
                                      4'd15, 2'(3 - s), 32'd0));
        send_request(make_request(qedp_pkg::ACT_EDGE, 4'd15, 2'd2, 32'd0,
                                  4'd15, 2'd2, 32'hFFFF_FFFF));
        send_request(make_request(qedp_pkg::ACT_EDGE, 4'd1, 2'd3, 32'hFFFF_FFF0,
                                  4'd1, 2'd1, 32'h1234_5678));
    endtask

    task automatic test_inner_nodes();
        for (int s = 0; s < 4; s++)
            send_request(make_request(qedp_pkg::ACT_INNER, 4'd15, 2'(s), 32'h8000_0000,
                                      4'd15, 2'(s), 32'h7FFF_FFFF));
        send_request(make_request(qedp_pkg::ACT_INNER, 4'd2, 2'd1, 32'd0, 4'd2, 2'd3, 32'd0));
    endtask

    task automatic test_corner_node();
        send_request(make_request(qedp_pkg::ACT_CORNER, 4'd15, 2'd1, 32'hFFFF_FFFF,
                                  4'd15, 2'd3, 32'hFFFF_FFFF));
        send_request(make_request(qedp_pkg::ACT_CORNER, 4'd7, 2'd2, 32'd100,
                                  4'd7, 2'd0, 32'd200));
        send_request(make_request(qedp_pkg::ACT_CORNER, 4'd0, 2'd3, 32'd5, 4'd0, 2'd1, 32'd9));
    endtask

    task automatic test_order_mismatch();
        send_request(make_request(qedp_pkg::ACT_EDGE, 4'd15, 2'd0, 32'hFFFF_FFFF,
                                  4'd0, 2'd3, 32'hFFFF_FFFF));
        send_request(make_request(qedp_pkg::ACT_CORNER, 4'd1, 2'd2, 32'd0, 4'd2, 2'd2, 32'd0));
    endtask

    // The unused action, walks with nothing to emit, and a short edge walk.
    task automatic test_ignored_and_empty();
        send_request(make_request(qedp_pkg::ACT_NONE, 4'd15, 2'd3, 32'hFFFF_FFFF,
                                  4'd15, 2'd3, 32'hFFFF_FFFF));
        send_request(make_request(qedp_pkg::ACT_EDGE, 4'd0, 2'd1, 32'd1, 4'd0, 2'd2, 32'd2));
        send_request(make_request(qedp_pkg::ACT_INNER, 4'd0, 2'd0, 32'd3, 4'd0, 2'd0, 32'd4));
        send_request(make_request(qedp_pkg::ACT_INNER, 4'd1, 2'd3, 32'd5, 4'd1, 2'd1, 32'd6));
        send_request(make_request(qedp_pkg::ACT_EDGE, 4'd3, 2'd0, 32'd7, 4'd3, 2'd2, 32'd8));
    endtask

    // Random requests under one sender idle rate.
    task automatic test_random(input int items, input int idle_pct);
        qedp_pkg::req_t r;
        for (int i = 0; i < items; i++)
        begin
            r = random_request();
            sender_gap(idle_pct);
            send_request(r);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        sent_count  = 0;
        pair_count  = 0;
        error_count = 0;
        cycle_count = 0;

        // Hold reset, then release it at a falling edge.
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_walks();
        test_inner_nodes();
        test_corner_node();
        test_order_mismatch();
        test_ignored_and_empty();

        // Back-to-back, then a mostly idle sender, then a lightly idle one.
        test_random(RANDOM_ITEMS / 3, 0);
        test_random(RANDOM_ITEMS / 3, 58);
        test_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 36);

        @(negedge clk);
        start <= 1'b0;

        // Drain the outstanding pairs, then give the block time to misbehave.
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        error_count += pending_pairs.size();
        $display("Sent %0d requests (edge, inner, corner, mismatch, unused), checked %0d pairs",
                 sent_count, pair_count);
        $display("Sender idle rates 0/58/36 percent, %0d mismatches in %0d cycles",
                 error_count, cycle_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
